// ===== design/chs_pkg.sv =====
// Package: shared types, constants and a hash helper for the chained hash store.
package chs_pkg;

  localparam int ENTRY_CAP  = 1024;
  localparam int BUCKET_CAP = 1024;
  localparam int IDX_W      = 11;   // entry index incl. null
  localparam int EIDX_W     = 10;   // entry address
  localparam int BIDX_W     = 10;   // bucket address
  localparam logic [IDX_W-1:0] NIL_IDX = IDX_W'(ENTRY_CAP);

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_CHANGE = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_DUP    = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [0:0] REG_BUCKET_COUNT = 1'd0;
  localparam logic [0:0] REG_KEY_BYTES    = 1'd1;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] key;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] value_out;
    logic [1:0]  status;
  } rsp_t;

  // Classified request handed from front to back.
  typedef struct packed {
    logic [1:0]        action;
    logic [63:0]       key;
    logic [63:0]       value;
    logic [BIDX_W-1:0] bucket;
  } job_t;

  // One ELF/PJW-style step on a sign-extended byte.
  function automatic logic [31:0] elf_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] t;
    logic [31:0] hi;
    t  = (h << 4) + {{24{b[7]}}, b};
    hi = t & 32'hF000_0000;
    if (hi != 32'd0) begin
      t = (t ^ (t >> 24)) & ~hi;
    end
    return t;
  endfunction

endpackage

// ===== design/chained_hash_key_value_store.sv =====
// Top level of the chained hash key/value store.
//
//   channel   signals                          beat taken when
//   request   start, busy, req                 start && !busy
//   result    done, rsp                        done (one cycle, no stall)
//   config    psel, penable, pwrite, paddr,    psel && penable && pwrite
//             pwdata, prdata, pready
//
// A request is first hashed byte by byte and reduced to a bucket in the front end,
// then walks its chain one entry at a time in the back end; front and back overlap
// through a one-deep queue, so with short chains the front sets the rate and
// a long chain walk holds the front once its queue slot is full.
// After reset, and after every register write, a clearing pass over all 1024
// bucket heads empties them; busy stays high during it.
// The result side cannot stall: each result beat shows on done for one cycle.
module chained_hash_key_value_store
  import chs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  req_t        req,
  output logic        busy,
  output logic        done,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [10:0] bucket_count;
  logic [3:0]  key_bytes;
  logic [3:0]  eff_bytes;
  logic [10:0] eff_buckets;
  logic [63:0] key_mask;
  logic        cfg_we;
  logic        clearing;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // Clamp the registers to their usable range.
  assign eff_bytes   = (key_bytes == 4'd0) ? 4'd1 : (key_bytes > 4'd8) ? 4'd8 : key_bytes;
  assign eff_buckets = (bucket_count == 11'd0) ? 11'd1 :
                       (bucket_count > 11'(BUCKET_CAP)) ? 11'(BUCKET_CAP) : bucket_count;
  always_comb begin
    key_mask = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < int'(eff_bytes)) key_mask[i*8 +: 8] = 8'hFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= 11'd673;
      key_bytes    <= 4'd8;
    end else if (cfg_we && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_BUCKET_COUNT) bucket_count <= pwdata[10:0];
      else                              key_bytes    <= pwdata[3:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    case (paddr[2])
      REG_BUCKET_COUNT: prdata = {21'd0, bucket_count};
      REG_KEY_BYTES:    prdata = {28'd0, key_bytes};
      default:          prdata = 32'd0;
    endcase
  end

  // Front -> back queue: the front's held output acts as one-deep queue slot.
  logic f_ready, q_valid, q_ready;
  job_t q_job;

  chs_front u_front (
    .clk, .rst(rst || (cfg_we && paddr[1:0] == 2'b00)),
    .in_valid(start && !busy), .in_req(req), .in_ready(f_ready),
    .eff_bytes, .eff_buckets,
    .out_valid(q_valid), .out_job(q_job), .out_ready(q_ready)
  );

  chs_back u_back (
    .clk, .rst, .clear(cfg_we && paddr[1:0] == 2'b00), .key_mask,
    .job_valid(q_valid), .job_in(q_job), .job_ready(q_ready),
    .clearing, .rsp_valid(done), .rsp
  );

  assign busy = !f_ready || clearing;

  // No result appears while clearing, busy covers clearing, and the back takes one job at a time.
  a_no_done_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !done) else $error("result during clear");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    clearing |-> busy) else $error("accept while clearing");
  a_handoff: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |=> !q_ready) else $error("back took two jobs");
endmodule

// ===== design/chs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module chs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/chs_front.sv =====
// Front end: byte-serial hash and restoring modulo reduction to a bucket.
module chs_front
  import chs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  req_t        in_req,
  output logic        in_ready,
  input  logic [3:0]  eff_bytes,
  input  logic [10:0] eff_buckets,
  output logic        out_valid,
  output job_t        out_job,
  input  logic        out_ready
);
  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_HASH = 2'd1;
  localparam logic [1:0] F_MOD  = 2'd2;
  localparam logic [1:0] F_OUT  = 2'd3;

  logic [1:0]  state;
  req_t        req;
  logic [31:0] h;
  logic [3:0]  cnt;
  logic [5:0]  mcnt;
  logic [10:0] rem;
  logic [11:0] trial;

  assign in_ready  = (state == F_IDLE);
  assign out_valid = (state == F_OUT);
  assign out_job   = '{action: req.action, key: req.key, value: req.value,
                       bucket: rem[BIDX_W-1:0]};
  assign trial     = {rem, h[31]} - {1'b0, eff_buckets};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: if (in_valid) begin
          req   <= in_req;
          h     <= 32'd0;
          cnt   <= 4'd0;
          state <= F_HASH;
        end
        F_HASH: begin
          h   <= elf_step(h, req.key[{cnt[2:0], 3'b000} +: 8]);
          cnt <= cnt + 4'd1;
          if (cnt + 4'd1 == eff_bytes) begin
            rem   <= 11'd0;
            mcnt  <= 6'd0;
            state <= F_MOD;
          end
        end
        F_MOD: begin
          // one quotient bit a cycle, MSB first
          rem  <= trial[11] ? {rem[9:0], h[31]} : trial[10:0];
          h    <= {h[30:0], 1'b0};
          mcnt <= mcnt + 6'd1;
          if (mcnt == 6'd31) state <= F_OUT;
        end
        F_OUT: if (out_ready) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end
endmodule

// ===== design/chs_back.sv =====
// Back end: bucket head clear, chain walk, and insert/lookup/delete/change.
module chs_back
  import chs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        clear,
  input  logic [63:0] key_mask,
  input  logic        job_valid,
  input  job_t        job_in,
  output logic        job_ready,
  output logic        clearing,
  output logic        rsp_valid,
  output rsp_t        rsp
);
  localparam logic [2:0] B_CLR   = 3'd0;
  localparam logic [2:0] B_IDLE  = 3'd1;
  localparam logic [2:0] B_HEAD  = 3'd2;
  localparam logic [2:0] B_READ  = 3'd3;
  localparam logic [2:0] B_CMP   = 3'd4;
  localparam logic [2:0] B_FREE  = 3'd5;
  localparam logic [2:0] B_ALLOC = 3'd6;

  logic [2:0]        state;
  job_t              job;
  logic [BIDX_W:0]   clr_cnt;
  logic [IDX_W-1:0]  cur, prev;
  logic [IDX_W-1:0]  steps;
  logic [IDX_W-1:0]  count;
  logic [EIDX_W-1:0] fl_top;  // free list read result

  // memories
  logic              hd_we;  logic [BIDX_W-1:0] hd_wa, hd_ra;
  logic [IDX_W-1:0]  hd_wd, hd_rd;
  logic              k_we;   logic [EIDX_W-1:0] e_wa, e_ra;
  logic [63:0]       k_rd;
  logic              v_we;   logic [63:0] v_wd, v_rd;
  logic              n_we;   logic [EIDX_W-1:0] n_wa;
  logic [IDX_W-1:0]  n_wd, n_rd;
  logic              f_we;   logic [EIDX_W-1:0] f_wa, f_ra;
  logic [EIDX_W-1:0] f_wd, f_rd;
  logic              f_init;

  chs_ram #(.WIDTH(IDX_W),  .DEPTH(BUCKET_CAP)) u_head (.clk, .we(hd_we), .waddr(hd_wa),
    .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
  chs_ram #(.WIDTH(64),     .DEPTH(ENTRY_CAP))  u_key  (.clk, .we(k_we),  .waddr(e_wa),
    .wdata(job.key), .raddr(e_ra), .rdata(k_rd));
  chs_ram #(.WIDTH(64),     .DEPTH(ENTRY_CAP))  u_val  (.clk, .we(v_we),  .waddr(e_wa),
    .wdata(v_wd), .raddr(e_ra), .rdata(v_rd));
  chs_ram #(.WIDTH(IDX_W),  .DEPTH(ENTRY_CAP))  u_next (.clk, .we(n_we),  .waddr(n_wa),
    .wdata(n_wd), .raddr(e_ra), .rdata(n_rd));
  chs_ram #(.WIDTH(EIDX_W), .DEPTH(ENTRY_CAP))  u_free (.clk, .we(f_we),  .waddr(f_wa),
    .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

  // Free list slots beyond those ever pushed hold their initial entry: a
  // fill mark (count of slots written since clear) avoids a clearing pass.
  logic [IDX_W-1:0] f_hi;     // slots [ENTRY_CAP-f_hi .. ] were ever written
  logic [IDX_W-1:0] slot;
  assign slot   = IDX_W'(ENTRY_CAP - 1) - count;
  assign f_init = ({1'b0, slot[EIDX_W-1:0]} < IDX_W'(ENTRY_CAP) - f_hi);
  assign fl_top = f_init ? EIDX_W'(IDX_W'(ENTRY_CAP - 1) - slot) : f_rd;

  logic match;
  assign match = ((k_rd ^ job.key) & key_mask) == 64'd0;

  assign job_ready = (state == B_IDLE) && !clear;
  assign clearing  = (state == B_CLR);

  always_comb begin
    hd_we = 1'b0; hd_wa = job.bucket; hd_wd = NIL_IDX; hd_ra = job.bucket;
    k_we = 1'b0; v_we = 1'b0; n_we = 1'b0; e_wa = cur[EIDX_W-1:0];
    v_wd = job.value; n_wd = n_rd; n_wa = prev[EIDX_W-1:0];
    e_ra = cur[EIDX_W-1:0];
    f_we = 1'b0; f_wa = slot[EIDX_W-1:0]; f_wd = cur[EIDX_W-1:0];
    f_ra = slot[EIDX_W-1:0];
    case (state)
      B_CLR: begin
        hd_we = 1'b1; hd_wa = clr_cnt[BIDX_W-1:0];
      end
      B_IDLE: hd_ra = job_in.bucket;
      B_HEAD: e_ra = hd_rd[EIDX_W-1:0];
      B_CMP: begin
        e_ra = n_rd[EIDX_W-1:0];
        if (match && job.action == ACT_DELETE) begin
          if (prev == NIL_IDX) begin
            hd_we = 1'b1; hd_wd = n_rd;
          end else begin
            n_we = 1'b1;
          end
        end
        if (match && job.action == ACT_CHANGE) v_we = 1'b1;
      end
      B_FREE: begin
        f_we = 1'b1;
      end
      B_ALLOC: begin
        e_wa = fl_top; k_we = 1'b1; v_we = 1'b1;
        n_we = 1'b1; n_wa = fl_top; n_wd = hd_rd;
        hd_we = 1'b1; hd_wd = {1'b0, fl_top};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rsp_valid <= 1'b0;
    if (rst || clear) begin
      state   <= B_CLR;
      clr_cnt <= '0;
      count   <= '0;
      f_hi    <= '0;
    end else begin
      case (state)
        B_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (BIDX_W+1)'(BUCKET_CAP - 1)) state <= B_IDLE;
        end
        B_IDLE: if (job_valid) begin
          job   <= job_in;
          state <= B_HEAD;
        end
        B_HEAD: begin
          cur   <= hd_rd;
          prev  <= NIL_IDX;
          steps <= '0;
          state <= B_READ;
        end
        B_READ: begin
          if (cur == NIL_IDX || steps == IDX_W'(ENTRY_CAP)) begin
            // miss
            if ((job.action == ACT_INSERT || job.action == ACT_CHANGE)) begin
              if (count == IDX_W'(ENTRY_CAP)) begin
                rsp <= '{hit: 1'b0, value_out: 64'd0, status: ST_FULL};
                rsp_valid <= 1'b1;
                state <= B_IDLE;
              end else begin
                state <= B_ALLOC;
              end
            end else begin
              rsp <= '{hit: 1'b0, value_out: 64'd0, status: ST_ABSENT};
              rsp_valid <= 1'b1;
              state <= B_IDLE;
            end
          end else begin
            state <= B_CMP;   // entry data now readable
          end
        end
        B_CMP: begin
          if (match) begin
            rsp <= '{hit: 1'b1,
                     value_out: (job.action == ACT_LOOKUP) ? v_rd : 64'd0,
                     status: (job.action == ACT_INSERT) ? ST_DUP : ST_DONE};
            if (job.action == ACT_DELETE) begin
              count <= count - 1'b1;
              state <= B_FREE;
            end else begin
              rsp_valid <= 1'b1;
              state <= B_IDLE;
            end
          end else begin
            prev  <= cur;
            cur   <= n_rd;
            steps <= steps + 1'b1;
            state <= B_READ;
          end
        end
        B_FREE: begin
          // widen the fill mark when the pushed slot lies below it
          if (f_init) begin
            f_hi <= IDX_W'(ENTRY_CAP) - {1'b0, slot[EIDX_W-1:0]};
          end
          rsp_valid <= 1'b1;
          state <= B_IDLE;
        end
        B_ALLOC: begin
          count <= count + 1'b1;
          rsp <= '{hit: 1'b0, value_out: 64'd0, status: ST_DONE};
          rsp_valid <= 1'b1;
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule

// ===== dv/chs_checker.sv =====
// Checker for the chained hash store: watches request, result and register beats, predicts, compares.
module chs_checker
  import chs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  req_t        req,
  input  logic        done,
  input  rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [10:0] cfg_buckets;
  logic [3:0]  cfg_kbytes;
  int          heads [BUCKET_CAP];
  logic [63:0] ekey  [ENTRY_CAP];
  logic [63:0] evalue[ENTRY_CAP];
  int          enext [ENTRY_CAP];
  int          free_ids[ENTRY_CAP];
  int          used;
  rsp_t        rsp_queue[$];

  assign pending = rsp_queue.size();

  function automatic void empty_store();
    for (int i = 0; i < BUCKET_CAP; i++) heads[i] = ENTRY_CAP;
    for (int i = 0; i < ENTRY_CAP; i++) begin
      ekey[i] = '0;
      evalue[i] = '0;
      enext[i] = ENTRY_CAP;
      free_ids[i] = ENTRY_CAP - 1 - i;
    end
    used = 0;
  endfunction

  // Hash, walk the chain and update the model for one request beat.
  function automatic rsp_t serve(req_t r);
    int          nb;
    int          kb;
    logic [63:0] kmask;
    logic [31:0] h;
    logic [31:0] hi;
    logic [7:0]  b;
    int          bkt;
    int          cur;
    int          prv;
    int          found;
    int          steps;
    int          e;
    rsp_t        o;
    nb = (cfg_buckets == 0) ? 1 : (cfg_buckets > BUCKET_CAP) ? BUCKET_CAP : int'(cfg_buckets);
    kb = (cfg_kbytes == 0) ? 1 : (cfg_kbytes > 8) ? 8 : int'(cfg_kbytes);
    kmask = (kb == 8) ? '1 : ((64'd1 << (8 * kb)) - 64'd1);
    h = '0;
    for (int i = 0; i < kb; i++) begin
      b = r.key[8*i +: 8];
      h = (h << 4) + {{24{b[7]}}, b};
      hi = h & 32'hF000_0000;
      if (hi != 0) h = (h ^ (h >> 24)) & ~hi;
    end
    bkt = int'(h % nb);
    cur = heads[bkt];
    prv = ENTRY_CAP;
    found = ENTRY_CAP;
    steps = 0;
    while (cur < ENTRY_CAP && steps < ENTRY_CAP && found == ENTRY_CAP) begin
      if (((ekey[cur] ^ r.key) & kmask) == 0) found = cur;
      else begin
        prv = cur;
        cur = enext[cur];
        steps++;
      end
    end
    o.hit = (found < ENTRY_CAP);
    o.value_out = '0;
    o.status = ST_DONE;
    case (r.action)
      ACT_LOOKUP: begin
        if (o.hit) o.value_out = evalue[found];
        else o.status = ST_ABSENT;
      end
      ACT_DELETE: begin
        if (o.hit) begin
          if (prv < ENTRY_CAP) enext[prv] = enext[found];
          else heads[bkt] = enext[found];
          used--;
          free_ids[ENTRY_CAP - 1 - used] = found;
        end else o.status = ST_ABSENT;
      end
      default: begin
        if (o.hit) begin
          if (r.action == ACT_INSERT) o.status = ST_DUP;
          else evalue[found] = r.value;
        end else if (used >= ENTRY_CAP) o.status = ST_FULL;
        else begin
          e = free_ids[ENTRY_CAP - 1 - used];
          used++;
          ekey[e] = r.key;
          evalue[e] = r.value;
          enext[e] = heads[bkt];
          heads[bkt] = e;
        end
      end
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      cfg_buckets <= 11'd673;
      cfg_kbytes <= 4'd8;
      empty_store();
      rsp_queue.delete();
      fails <= 0;
    end else begin
      // Compare results first so a beat never matches a request taken this cycle.
      if (done) begin
        if (rsp_queue.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %p", $realtime, rsp);
          fails <= fails + 1;
        end else begin
          want = rsp_queue.pop_front();
          if (rsp.hit !== want.hit || rsp.value_out !== want.value_out ||
              rsp.status !== want.status) begin
            $display("%0t result mismatch: expected %p, actual %p", $realtime, want, rsp);
            fails <= fails + 1;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_BUCKET_COUNT) cfg_buckets <= pwdata[10:0];
        else cfg_kbytes <= pwdata[3:0];
        empty_store();
      end
      if (start && !busy) rsp_queue.push_back(serve(req));
    end
  end

endmodule

// ===== dv/tb_chained_hash_key_value_store.sv =====
// Testbench top: clock, reset, request and register stimulus, and the final verdict.
module tb_chained_hash_key_value_store
  import chs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  req_t        req = '0;
  logic        busy;
  logic        done;
  rsp_t        rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fails;
  int          pending;
  int          cycles = 0;

  // Current setting, kept here to shape keys around the compared bytes.
  int          eff_kbytes = 8;
  logic [63:0] key_pool[24];
  int          burst_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  chained_hash_key_value_store u_top (
    .clk, .rst, .start, .req, .busy, .done, .rsp,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  chs_checker u_check (
    .clk, .rst, .start, .busy, .req, .done, .rsp,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fails, .pending
  );

  // Cap the run; a hang anywhere ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Drive one request beat and hold it until taken; then maybe open a gap.
  task automatic send(logic [1:0] act, logic [63:0] k, logic [63:0] v);
    start <= 1'b1;
    req <= '{action: act, key: k, value: v};
    do @(posedge clk); while (busy);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Drain outstanding results, idle a while, then do one APB write.
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pwdata <= $urandom();
    @(posedge clk);
  endtask

  task automatic set_store(logic [31:0] buckets, logic [31:0] kbytes);
    write_reg({REG_BUCKET_COUNT, 2'b00}, buckets);
    write_reg({REG_KEY_BYTES, 2'b00}, kbytes);
    eff_kbytes = (kbytes[3:0] == 0) ? 1 : (kbytes[3:0] > 8) ? 8 : int'(kbytes[3:0]);
    foreach (key_pool[i]) key_pool[i] = rand64();
  endtask

  // Mostly keys from a small pool so chains hold hits; vary the ignored upper bytes.
  function automatic logic [63:0] pick_key();
    logic [63:0] m;
    logic [63:0] k;
    m = (eff_kbytes == 8) ? '1 : ((64'd1 << (8 * eff_kbytes)) - 64'd1);
    if ($urandom_range(0, 9) == 0) return rand64();
    k = key_pool[$urandom_range(0, 23)];
    if ($urandom_range(0, 2) == 0) k = (k & m) | (rand64() & ~m);
    return k;
  endfunction

  task automatic random_ops(int n);
    int r;
    logic [1:0] act;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      act = (r < 30) ? ACT_INSERT : (r < 60) ? ACT_LOOKUP : (r < 80) ? ACT_DELETE : ACT_CHANGE;
      send(act, pick_key(), rand64());
    end
  endtask

  initial begin
    logic [63:0] k;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every action, hit and miss, duplicate, field extremes, sign-extended bytes.
    k = 64'h0123_4567_89AB_CDEF;
    send(ACT_LOOKUP, k, '0);
    send(ACT_INSERT, k, 64'h1111);
    send(ACT_LOOKUP, k, '1);
    send(ACT_INSERT, k, 64'h2222);
    send(ACT_CHANGE, k, '1);
    send(ACT_LOOKUP, k, '0);
    send(ACT_DELETE, k, '0);
    send(ACT_DELETE, k, '0);
    send(ACT_LOOKUP, k, '0);
    send(ACT_CHANGE, k, 64'h3333);
    send(ACT_LOOKUP, k, '0);
    send(ACT_INSERT, '0, '1);
    send(ACT_INSERT, '1, '0);
    send(ACT_INSERT, 64'h8080_8080_8080_80FF, 64'hA5A5_5A5A_A5A5_5A5A);
    send(ACT_INSERT, 64'hFF7F_FF80_0001_7FFE, 64'h5A5A_A5A5_5A5A_A5A5);
    send(ACT_LOOKUP, '0, '0);
    send(ACT_LOOKUP, '1, '0);
    send(ACT_LOOKUP, 64'h8080_8080_8080_80FF, '0);
    send(ACT_LOOKUP, 64'hFF7F_FF80_0001_7FFE, '0);
    send(ACT_DELETE, '1, '0);
    send(ACT_LOOKUP, '1, '0);

    // Largest bucket count.
    set_store(32'd1024, 32'd8);
    random_ops(40);

    // Sweep settings: out-of-range low and high, smallest, and odd sizes.
    set_store(32'd0, 32'd0);
    random_ops(70);
    set_store(32'd2047, 32'd15);
    random_ops(70);
    set_store(32'd1, 32'd1);
    random_ops(60);
    set_store(($urandom() & 32'hFFFF_F800) | 32'd5, ($urandom() & 32'hFFFF_FFF0) | 32'd3);
    random_ops(80);
    set_store(32'd673, 32'd8);
    random_ops(80);
    set_store(32'h0000_0007, 32'hFFFF_FFF2);
    random_ops(50);

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
